### hw/rtl/sfce_pkg.sv
package sfce_pkg;

	// Field widths fixed by the item format.
	localparam int MASK_W  = 18;
	localparam int ANGLE_W = 13;
	localparam int CAL_W   = 12;
	localparam int CHAN_W  = 5;

	// Function codes of an input word.
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_ANGLE = 2'd1;
	localparam logic [1:0] FUNC_CAL   = 2'd2;

	// Spans in sixteenths of a degree (90 and 135 degrees).
	localparam logic [11:0] SPAN_NARROW = 12'd1440;
	localparam logic [11:0] SPAN_WIDE   = 12'd2160;

	// A span divide is a shift (by 32 or 16) and then a divide by 45 or 135.
	localparam logic [7:0]  DIV_NARROW = 8'd45;
	localparam logic [7:0]  DIV_WIDE   = 8'd135;
	// Reciprocals scaled by 2^24, rounded down.
	localparam logic [18:0] RCP_NARROW = 19'd372827;
	localparam logic [18:0] RCP_WIDE   = 19'd124275;

	// Byte split of the pulse: hundreds and remainder.
	localparam logic [7:0]  DIV_BASE = 8'd100;
	// Reciprocal of 100 scaled by 2^20, rounded down.
	localparam logic [13:0] RCP_BASE = 14'd10485;

	// One calibration entry.
	typedef struct packed {
		logic              narrow;
		logic [CAL_W-1:0]  cmax;
		logic [CAL_W-1:0]  cmid;
		logic [CAL_W-1:0]  cmin;
	} cal_t;

	// Arithmetic steps of the datapath sequencer.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL,
		OP_SUM,
		OP_RECIP,
		OP_CHECK,
		OP_FIX,
		OP_DIV,
		OP_FIX100
	} dp_op_t;

	// Source of an emitted byte.
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_ONE,
		SEL_HI,
		SEL_LO
	} byte_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      ld_angle;
		logic      cal_wr;
		dp_op_t    op;
		logic      emit;
		byte_sel_t emit_sel;
		logic      last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/sfce_ctrl.sv
module sfce_ctrl #(
	parameter int NUM_CHANNELS = 18,
	parameter int CNT_W        = 5,
	parameter int IDX_W        = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic [1:0]                  func,
	input  logic [sfce_pkg::MASK_W-1:0] pin_mask,
	input  logic [sfce_pkg::CHAN_W-1:0] channel,
	input  sfce_pkg::sts_t              sts,
	output sfce_pkg::cmd_t              cmd,
	output logic [IDX_W-1:0]            rd_idx
);
	import sfce_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UHI,
		ST_ULO,
		ST_MUL,
		ST_SUM,
		ST_RECIP,
		ST_CHECK,
		ST_FIX,
		ST_DIV,
		ST_FIX100,
		ST_MHI,
		ST_MLO
	} state_t;

	state_t              state_q;
	logic [MASK_W-1:0]   mask_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                open_q;

	logic                accept;
	logic                cnt_in_range;
	logic                cnt_is_last;
	logic                chan_ok;
	logic [MASK_W-1:0]   mask_sh;
	logic                sel_cur;

	// Decode of the current channel and of the incoming word.
	assign accept       = (state_q == ST_IDLE) && item_valid;
	assign cnt_in_range = cnt_q < CNT_W'(NUM_CHANNELS);
	assign cnt_is_last  = cnt_q == CNT_W'(NUM_CHANNELS - 1);
	assign chan_ok      = {1'b0, channel} < (CHAN_W + 1)'(NUM_CHANNELS);
	assign mask_sh      = mask_q >> cnt_q;
	assign sel_cur      = mask_sh[0];
	assign item_stall   = state_q != ST_IDLE;
	assign rd_idx       = cnt_q[IDX_W-1:0];

	// Command decode from the state.
	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.emit_sel = SEL_ZERO;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ld_angle = accept && (func == FUNC_ANGLE) && open_q && cnt_in_range;
				cmd.cal_wr   = accept && (func == FUNC_CAL) && chan_ok;
			end
			ST_SCAN: ;
			ST_UHI: begin
				cmd.emit     = sts.out_free;
				cmd.emit_sel = SEL_ZERO;
			end
			ST_ULO: begin
				cmd.emit     = sts.out_free;
				cmd.emit_sel = SEL_ONE;
				cmd.last     = cnt_is_last;
			end
			ST_MUL:    cmd.op = OP_MUL;
			ST_SUM:    cmd.op = OP_SUM;
			ST_RECIP:  cmd.op = OP_RECIP;
			ST_CHECK:  cmd.op = OP_CHECK;
			ST_FIX:    cmd.op = OP_FIX;
			ST_DIV:    cmd.op = OP_DIV;
			ST_FIX100: cmd.op = OP_FIX100;
			ST_MHI: begin
				cmd.emit     = sts.out_free;
				cmd.emit_sel = SEL_HI;
			end
			ST_MLO: begin
				cmd.emit     = sts.out_free;
				cmd.emit_sel = SEL_LO;
				cmd.last     = cnt_is_last;
			end
		endcase
	end

	// Frame sequencer: mask, channel counter and open flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
			cnt_q   <= '0;
			open_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (func)
							FUNC_START: begin
								mask_q  <= pin_mask;
								cnt_q   <= '0;
								open_q  <= 1'b1;
								state_q <= ST_SCAN;
							end
							FUNC_ANGLE: begin
								if (open_q && cnt_in_range) begin
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					priority if (!cnt_in_range) begin
						open_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (sel_cur) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_UHI;
					end
				end
				ST_UHI: begin
					if (sts.out_free) begin
						state_q <= ST_ULO;
					end
				end
				ST_ULO: begin
					if (sts.out_free) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_MUL:    state_q <= ST_SUM;
				ST_SUM:    state_q <= ST_RECIP;
				ST_RECIP:  state_q <= ST_CHECK;
				ST_CHECK:  state_q <= ST_FIX;
				ST_FIX:    state_q <= ST_DIV;
				ST_DIV:    state_q <= ST_FIX100;
				ST_FIX100: state_q <= ST_MHI;
				ST_MHI: begin
					if (sts.out_free) begin
						state_q <= ST_MLO;
					end
				end
				ST_MLO: begin
					if (sts.out_free) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// An open frame waiting for an angle always points at a selected channel.
	a_open_points_selected: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && open_q) |-> (cnt_in_range && sel_cur))
		else $error("open frame waits on an unselected or out-of-range channel");

	// The final byte of a frame moves the counter past the last channel.
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_SCAN && cnt_q == CNT_W'(NUM_CHANNELS)))
		else $error("final byte did not end the frame");

	// The controller leaves idle only on an accepted word.
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !item_valid) |=> (state_q == ST_IDLE))
		else $error("controller left idle without an input word");
`endif

endmodule

### hw/rtl/sfce_dp.sv
module sfce_dp #(
	parameter int NUM_CHANNELS = 18,
	parameter int PULSE_WIDTH  = 12,
	parameter int IDX_W        = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfce_pkg::cmd_t                     cmd,
	output sfce_pkg::sts_t                     sts,
	input  logic [IDX_W-1:0]                   rd_idx,
	input  logic [IDX_W-1:0]                   wr_idx,
	input  logic signed [sfce_pkg::ANGLE_W-1:0] angle,
	input  logic [sfce_pkg::CAL_W-1:0]         cal_min,
	input  logic [sfce_pkg::CAL_W-1:0]         cal_mid,
	input  logic [sfce_pkg::CAL_W-1:0]         cal_max,
	input  logic                               narrow_span,
	input  logic                               byte_stall,
	output logic                               byte_valid,
	output logic [7:0]                         msg_byte,
	output logic                               is_last
);
	import sfce_pkg::*;

	localparam int PMAX = (1 << PULSE_WIDTH) - 1;

	cal_t                       cal_mem [NUM_CHANNELS];
	cal_t                       cal_rd_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic signed [26:0]         prod_q;
	logic [23:0]                basexs_q;
	logic [27:0]                num_q;
	logic [20:0]                m_q;
	logic [15:0]                q_q;
	logic [23:0]                qd_q;
	logic [PULSE_WIDTH-1:0]     pulse_q;
	logic [7:0]                 h_q;
	logic [7:0]                 hi_q;
	logic [7:0]                 lo_q;
	logic                       byte_valid_q;
	logic [7:0]                 byte_q;
	logic                       last_q;

	logic                       pos;
	logic [11:0]                span;
	logic [7:0]                 dv;
	logic [18:0]                rcp;
	logic signed [13:0]         x;
	logic signed [12:0]         d;
	logic [CAL_W-1:0]           base;
	logic [20:0]                m;
	logic [39:0]                rmul;
	logic [23:0]                r;
	logic [15:0]                qc;
	logic [27:0]                p100;
	logic [14:0]                hd;
	logic [14:0]                rem;
	logic [7:0]                 out_mux;

	// Calibration store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.cal_wr) begin
			cal_mem[wr_idx] <= '{narrow: narrow_span, cmax: cal_max,
				cmid: cal_mid, cmin: cal_min};
		end
		if (cmd.ld_angle) begin
			cal_rd_q <= cal_mem[rd_idx];
			angle_q  <= angle;
		end
	end

	// Segment choice and span constants of the current entry.
	always_comb begin
		pos  = !angle_q[ANGLE_W-1];
		span = cal_rd_q.narrow ? SPAN_NARROW : SPAN_WIDE;
		dv   = cal_rd_q.narrow ? DIV_NARROW : DIV_WIDE;
		rcp  = cal_rd_q.narrow ? RCP_NARROW : RCP_WIDE;
		if (pos) begin
			x    = 14'(angle_q);
			d    = signed'({1'b0, cal_rd_q.cmax}) - signed'({1'b0, cal_rd_q.cmid});
			base = cal_rd_q.cmid;
		end else begin
			x    = 14'(angle_q) + signed'({2'b00, span});
			d    = signed'({1'b0, cal_rd_q.cmid}) - signed'({1'b0, cal_rd_q.cmin});
			base = cal_rd_q.cmin;
		end
	end

	// Per-step arithmetic; a negative numerator is divided too, and the fix step then clamps the pulse to zero.
	always_comb begin
		m    = cal_rd_q.narrow ? {1'b0, num_q[24:5]} : num_q[24:4];
		rmul = 40'(m) * 40'(rcp);
		r    = {3'b000, m_q} - qd_q;
		qc   = q_q + 16'(r >= 24'(dv));
		p100 = 28'(pulse_q) * 28'(RCP_BASE);
		hd   = 15'(h_q) * 15'(DIV_BASE);
		rem  = 15'(pulse_q) - hd;
	end

	// Sequenced datapath registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_NONE: ;
			OP_MUL: begin
				prod_q   <= 27'(x) * 27'(d);
				basexs_q <= 24'(base) * 24'(span);
			end
			OP_SUM: begin
				num_q <= 28'(prod_q) + 28'(basexs_q);
			end
			OP_RECIP: begin
				m_q <= m;
				q_q <= rmul[39:24];
			end
			OP_CHECK: begin
				qd_q <= 24'(q_q) * 24'(dv);
			end
			OP_FIX: begin
				priority if (num_q[27]) begin
					pulse_q <= '0;
				end else if (qc > 16'(PMAX)) begin
					pulse_q <= PULSE_WIDTH'(PMAX);
				end else begin
					pulse_q <= qc[PULSE_WIDTH-1:0];
				end
			end
			OP_DIV: begin
				h_q <= p100[27:20];
			end
			OP_FIX100: begin
				if (rem >= 15'(DIV_BASE)) begin
					hi_q <= h_q + 8'd1;
					lo_q <= 8'(rem - 15'(DIV_BASE));
				end else begin
					hi_q <= h_q;
					lo_q <= 8'(rem);
				end
			end
		endcase
	end

	// Output word selection.
	always_comb begin
		unique case (cmd.emit_sel)
			SEL_ZERO: out_mux = 8'd0;
			SEL_ONE:  out_mux = 8'd1;
			SEL_HI:   out_mux = hi_q;
			SEL_LO:   out_mux = lo_q;
		endcase
	end

	// Output register with its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			byte_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			byte_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= out_mux;
			last_q <= cmd.last;
		end
	end

	assign sts.out_free = !byte_valid_q || !byte_stall;
	assign byte_valid   = byte_valid_q;
	assign msg_byte     = byte_q;
	assign is_last      = last_q;

`ifndef SYNTHESIS
	// A new word is loaded only when the previous one has gone or is leaving.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!byte_valid_q || !byte_stall))
		else $error("output word overwritten while stalled");

	// The remainder byte is always below one hundred.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIX100) |=> (lo_q < DIV_BASE))
		else $error("pulse remainder out of range");

	// A negative numerator saturates the pulse to zero.
	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIX && num_q[27]) |=> (pulse_q == '0))
		else $error("negative pulse not clamped to zero");
`endif

endmodule

### hw/rtl/servo_frame_calibrated_encoder.sv
// Servo frame encoder with per-channel piecewise-linear calibration.
// Input channel (item_valid / item_stall): one word per handshake, decoded by
// func: start a frame with pin_mask, supply the next angle, or write the
// calibration entry of one channel. Output channel (byte_valid / byte_stall):
// one frame byte per word, pulse hundreds then pulse remainder for each
// channel, with is_last on the second byte of the final channel.
// A start word scans and loads both bytes of each unselected channel before
// the first selected one. An angle word runs the seven sequencer steps of the
// shared mapping and byte-split datapath, two byte loads and one scan, then a
// scan and two byte loads for each unselected channel that follows. The frame
// sequencer handles one word at a time and holds item_stall high until that
// word's bytes are all loaded; the last byte may still wait in the output
// register while the next word is accepted. A valid byte held by byte_stall
// stays in the output register and the sequencer waits at its byte loads.
// Reset clears the frame state and the output valid; the calibration store is
// not cleared and each channel must be written before its angles are sent.
module servo_frame_calibrated_encoder #(
	parameter int NUM_CHANNELS = 18,
	parameter int PULSE_WIDTH  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         func,
	input  logic [17:0]        pin_mask,
	input  logic signed [12:0] angle,
	input  logic [4:0]         channel,
	input  logic [11:0]        cal_min,
	input  logic [11:0]        cal_mid,
	input  logic [11:0]        cal_max,
	input  logic               narrow_span,
	output logic               byte_valid,
	input  logic               byte_stall,
	output logic [7:0]         msg_byte,
	output logic               is_last
);
	import sfce_pkg::*;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] rd_idx;

	// Frame controller.
	sfce_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func      (func),
		.pin_mask  (pin_mask),
		.channel   (channel),
		.sts       (sts),
		.cmd       (cmd),
		.rd_idx    (rd_idx)
	);

	// Calibration store, pulse mapping and output register.
	sfce_dp #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.PULSE_WIDTH (PULSE_WIDTH),
		.IDX_W       (IDX_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.rd_idx     (rd_idx),
		.wr_idx     (channel[IDX_W-1:0]),
		.angle      (angle),
		.cal_min    (cal_min),
		.cal_mid    (cal_mid),
		.cal_max    (cal_max),
		.narrow_span(narrow_span),
		.byte_stall (byte_stall),
		.byte_valid (byte_valid),
		.msg_byte   (msg_byte),
		.is_last    (is_last)
	);

endmodule

### tb/sv/sfce_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the servo frame encoder, predicts the frame bytes
// of every accepted input word and compares them with the bytes delivered.
module sfce_frame_checker #(
	parameter int NUM_CHANNELS = 18,
	parameter int PULSE_WIDTH  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         func,
	input  logic [17:0]        pin_mask,
	input  logic signed [12:0] angle,
	input  logic [4:0]         channel,
	input  logic [11:0]        cal_min,
	input  logic [11:0]        cal_mid,
	input  logic [11:0]        cal_max,
	input  logic               narrow_span,
	input  logic               byte_valid,
	input  logic               byte_stall,
	input  logic [7:0]         msg_byte,
	input  logic               is_last,
	output int                 fail_count,
	output int                 pending,
	output int                 bytes_checked
);
	import sfce_pkg::*;

	localparam longint PULSE_MAX = (longint'(1) << PULSE_WIDTH) - 1;
	// Keep the log readable when the design is badly broken.
	localparam int REPORT_CAP = 40;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} frame_byte_t;

	frame_byte_t       bytes_due[$];
	cal_t              cal_table[NUM_CHANNELS];
	logic [MASK_W-1:0] sel_mask;
	int                cur_ch;
	logic              open_frame;
	int                errors = 0;
	int                checked = 0;

	// Piecewise-linear map of a signed angle through one calibration entry.
	// Division truncates toward zero, then the pulse saturates.
	function automatic int calibrated_pulse(logic signed [ANGLE_W-1:0] a, cal_t c);
		longint s, lo, md, hi, x, p;
		s  = c.narrow ? longint'(SPAN_NARROW) : longint'(SPAN_WIDE);
		lo = longint'(c.cmin);
		md = longint'(c.cmid);
		hi = longint'(c.cmax);
		x  = longint'(a);
		if (x > 0)
			p = (x * (hi - md) + md * s) / s;
		else if (x < 0)
			p = ((x + s) * (md - lo) + lo * s) / s;
		else
			p = md;
		if (p < 0)
			p = 0;
		if (p > PULSE_MAX)
			p = PULSE_MAX;
		return int'(p);
	endfunction

	// Each channel contributes its pulse hundreds, then its remainder.
	task automatic queue_channel(int pulse, int ch);
		frame_byte_t b;
		b.value = 8'(pulse / 100);
		b.last  = 1'b0;
		bytes_due.push_back(b);
		b.value = 8'(pulse % 100);
		b.last  = (ch == NUM_CHANNELS - 1);
		bytes_due.push_back(b);
	endtask

	// Unselected channels encode a pulse of one; the frame closes at its end.
	task automatic queue_unselected();
		while (cur_ch < NUM_CHANNELS && !sel_mask[cur_ch]) begin
			queue_channel(1, cur_ch);
			cur_ch++;
		end
		if (cur_ch >= NUM_CHANNELS)
			open_frame = 1'b0;
	endtask

	// Compare delivered bytes first, then predict for the accepted input word.
	always @(posedge clk or negedge arst_n) begin
		frame_byte_t want;
		if (!arst_n) begin
			bytes_due.delete();
			sel_mask      = '0;
			cur_ch        = 0;
			open_frame    = 1'b0;
			pending       <= 0;
			fail_count    <= errors;
			bytes_checked <= checked;
		end else begin
			if (byte_valid && !byte_stall) begin
				checked++;
				if (bytes_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_CAP)
						$display("%0t: expected no byte, got msg_byte %0d is_last %0b",
							$time, msg_byte, is_last);
				end else begin
					want = bytes_due.pop_front();
					if (msg_byte !== want.value) begin
						errors++;
						if (errors <= REPORT_CAP)
							$display("%0t: msg_byte expected %0d, got %0d",
								$time, want.value, msg_byte);
					end
					if (is_last !== want.last) begin
						errors++;
						if (errors <= REPORT_CAP)
							$display("%0t: is_last expected %0b, got %0b",
								$time, want.last, is_last);
					end
				end
			end

			if (item_valid && !item_stall) begin
				case (func)
					FUNC_START: begin
						sel_mask   = pin_mask;
						cur_ch     = 0;
						open_frame = 1'b1;
						queue_unselected();
					end
					FUNC_ANGLE: begin
						// An angle outside an open frame is dropped.
						if (open_frame && cur_ch < NUM_CHANNELS) begin
							queue_channel(calibrated_pulse(angle, cal_table[cur_ch]), cur_ch);
							cur_ch++;
							queue_unselected();
						end
					end
					FUNC_CAL: begin
						if (channel < NUM_CHANNELS)
							cal_table[channel] = {narrow_span, cal_max, cal_mid, cal_min};
					end
					default: begin
					end
				endcase
			end

			pending       <= bytes_due.size();
			fail_count    <= errors;
			bytes_checked <= checked;
		end
	end

endmodule

### tb/sv/servo_frame_calibrated_encoder_tb.sv
`timescale 1ns / 1ps

module servo_frame_calibrated_encoder_tb;
	import sfce_pkg::*;

	localparam int NUM_CHANNELS = 18;
	localparam int ITEM_TARGET  = 470;
	localparam int HOLD_CYCLES  = 300;
	// Longest quiet stretch of a correct run is the hold-off plus one frame.
	localparam int QUIET_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 100;

	localparam logic [MASK_W-1:0] FIRST_CH = 18'h00001;
	localparam logic [MASK_W-1:0] LAST_CH  = 18'h20000;
	localparam logic [1:0]        FUNC_UNUSED = 2'd3;
	localparam int SPECIAL_ANGLES[9] = '{0, 1, -1, 2160, -2160, 1440, -1440, -4096, 4095};

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic [1:0]         func;
	logic [17:0]        pin_mask;
	logic signed [12:0] angle;
	logic [4:0]         channel;
	logic [11:0]        cal_min;
	logic [11:0]        cal_mid;
	logic [11:0]        cal_max;
	logic               narrow_span;
	logic               byte_valid;
	logic               byte_stall;
	logic [7:0]         msg_byte;
	logic               is_last;

	int fail_count;
	int pending;
	int bytes_checked;

	// Stimulus knobs and bookkeeping.
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int words_sent = 0;
	int ignored_words = 0;
	int frames_started = 0;
	int cal_writes = 0;
	int angles_left = 0;
	bit frame_live = 1'b0;

	servo_frame_calibrated_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.func        (func),
		.pin_mask    (pin_mask),
		.angle       (angle),
		.channel     (channel),
		.cal_min     (cal_min),
		.cal_mid     (cal_mid),
		.cal_max     (cal_max),
		.narrow_span (narrow_span),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.msg_byte    (msg_byte),
		.is_last     (is_last)
	);

	sfce_frame_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.func          (func),
		.pin_mask      (pin_mask),
		.angle         (angle),
		.channel       (channel),
		.cal_min       (cal_min),
		.cal_mid       (cal_mid),
		.cal_max       (cal_max),
		.narrow_span   (narrow_span),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.msg_byte      (msg_byte),
		.is_last       (is_last),
		.fail_count    (fail_count),
		.pending       (pending),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		byte_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				byte_stall <= 1'b1;
			end else begin
				byte_stall <= ($urandom_range(0, 99) < rx_stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no word moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (byte_valid && !byte_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("servo_frame_calibrated_encoder_tb failed");
		$finish;
	end

	function automatic cal_t rand_cal();
		cal_t c;
		c = 37'({$urandom(), $urandom()});
		// Pull each pulse to an end of its range now and then.
		if ($urandom_range(0, 4) == 0)
			c.cmin = {CAL_W{1'($urandom_range(0, 1))}};
		if ($urandom_range(0, 4) == 0)
			c.cmid = {CAL_W{1'($urandom_range(0, 1))}};
		if ($urandom_range(0, 4) == 0)
			c.cmax = {CAL_W{1'($urandom_range(0, 1))}};
		return c;
	endfunction

	// Mostly within the span, some anywhere in the field, some at the edges.
	function automatic int rand_angle();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return int'($urandom_range(0, 4320)) - 2160;
		else if (k < 75)
			return int'($urandom_range(0, 8191)) - 4096;
		else
			return SPECIAL_ANGLES[$urandom_range(0, 8)];
	endfunction

	// Offer one input word after a random gap and wait for its handshake.
	task automatic send_word(input logic [1:0] f, input logic [MASK_W-1:0] m,
			input logic signed [ANGLE_W-1:0] a, input logic [CHAN_W-1:0] ch, input cal_t c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		func        <= f;
		pin_mask    <= m;
		angle       <= a;
		channel     <= ch;
		cal_min     <= c.cmin;
		cal_mid     <= c.cmid;
		cal_max     <= c.cmax;
		narrow_span <= c.narrow;
		item_valid  <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic start_frame(input logic [MASK_W-1:0] m);
		send_word(FUNC_START, m, ANGLE_W'(rand_angle()), CHAN_W'($urandom()), rand_cal());
		frames_started++;
		angles_left = $countones(m);
		frame_live  = (angles_left != 0);
	endtask

	task automatic next_angle(input int a);
		send_word(FUNC_ANGLE, MASK_W'($urandom()), ANGLE_W'(a), CHAN_W'($urandom()),
			rand_cal());
		if (!frame_live) begin
			ignored_words++;
		end else begin
			angles_left--;
			if (angles_left == 0)
				frame_live = 1'b0;
		end
	endtask

	task automatic write_cal(input int ch, input cal_t c);
		send_word(FUNC_CAL, MASK_W'($urandom()), ANGLE_W'(rand_angle()), CHAN_W'(ch), c);
		if (ch < NUM_CHANNELS)
			cal_writes++;
		else
			ignored_words++;
	endtask

	task automatic send_unused();
		send_word(FUNC_UNUSED, MASK_W'($urandom()), ANGLE_W'(rand_angle()),
			CHAN_W'($urandom()), rand_cal());
		ignored_words++;
	endtask

	initial begin
		int progress;
		int kind;
		int pop;
		int cut;
		logic [MASK_W-1:0] m;
		bit pressure_done;

		pressure_done = 1'b0;
		arst_n      <= 1'b0;
		item_valid  <= 1'b0;
		func        <= FUNC_START;
		pin_mask    <= '0;
		angle       <= '0;
		channel     <= '0;
		cal_min     <= '0;
		cal_mid     <= '0;
		cal_max     <= '0;
		narrow_span <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words. Calibration entries are packed narrow, max, mid, min.
		next_angle(100);                                // no frame open: dropped
		send_unused();
		start_frame('0);                                // empty mask: whole frame at once
		write_cal(0, {1'b1, 12'd0, 12'd4095, 12'd0});
		write_cal(NUM_CHANNELS - 1, {1'b0, 12'd4095, 12'd0, 12'd4095});
		write_cal(NUM_CHANNELS, rand_cal());            // out of range: dropped
		write_cal(31, rand_cal());
		start_frame(FIRST_CH | LAST_CH);
		next_angle(4095);                               // saturates low
		next_angle(-4096);                              // saturates high
		start_frame(FIRST_CH);
		start_frame(LAST_CH);                           // abandons the open frame
		next_angle(2160);
		start_frame(FIRST_CH | LAST_CH);
		next_angle(0);
		write_cal(NUM_CHANNELS - 1, {1'b1, 12'd2000, 12'd1500, 12'd1000}); // mid-frame
		next_angle(-2160);
		next_angle(5);                                  // frame already closed
		write_cal(0, {1'b0, 12'd2000, 12'd1500, 12'd1000});
		start_frame(FIRST_CH);
		next_angle(1);
		start_frame(FIRST_CH);
		next_angle(-1);

		// Every channel gets an entry before random frames may select it.
		for (int ch = 0; ch < NUM_CHANNELS; ch++)
			write_cal(ch, rand_cal());

		// Random part: mostly complete frames with random masks and angles.
		while (words_sent - ignored_words < ITEM_TARGET) begin
			progress = words_sent - ignored_words;
			case ((progress / 50) % 4)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct  = 81;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct <= 81;
				end
				default: begin
					tx_idle_pct  = 19;
					rx_stall_pct <= 19;
				end
			endcase

			if (!pressure_done && progress >= 240 && !frame_live) begin
				// Receiver holds off while a full frame is pushed in, then drain.
				pressure_done = 1'b1;
				hold_req <= hold_req + 1;
				start_frame('1);
				repeat (NUM_CHANNELS) next_angle(rand_angle());
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end else begin
				kind = frame_live ? 99 : $urandom_range(0, 99);
				if (kind < 8) begin
					case ($urandom_range(0, 2))
						0: send_unused();
						1: write_cal($urandom_range(NUM_CHANNELS, 31), rand_cal());
						default: next_angle(rand_angle());
					endcase
				end else if (kind < 18) begin
					write_cal($urandom_range(0, NUM_CHANNELS - 1), rand_cal());
				end else begin
					kind = $urandom_range(0, 99);
					if (kind < 50) begin
						m = MASK_W'($urandom());
					end else if (kind < 80) begin
						m = '0;
						repeat ($urandom_range(1, 3)) m[$urandom_range(0, NUM_CHANNELS - 1)] = 1'b1;
					end else if (kind < 92) begin
						m = '1;
					end else begin
						m = '0;
					end
					pop = $countones(m);
					// Now and then leave a frame unfinished; a new start follows.
					cut = (pop > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, pop - 1) : pop;
					start_frame(m);
					for (int i = 0; i < cut; i++) begin
						if ($urandom_range(0, 19) == 0)
							write_cal($urandom_range(0, NUM_CHANNELS - 1), rand_cal());
						next_angle(rand_angle());
					end
				end
			end
		end

		// Let every expected byte arrive, then watch for stray ones.
		rx_stall_pct <= 0;
		item_valid   <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input words (%0d frame starts, %0d calibration writes, %0d dropped),",
			words_sent, frames_started, cal_writes, ignored_words);
		$display("checked %0d frame bytes under four idle mixes and a %0d-cycle output hold-off.",
			bytes_checked, HOLD_CYCLES);
		if (fail_count == 0)
			$display("servo_frame_calibrated_encoder_tb passed");
		else
			$display("servo_frame_calibrated_encoder_tb failed");
		$finish;
	end

endmodule
